@@ rtl/rgbhsv_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths and the divider iteration for the rgb to hsv converter
// no dependencies; imported by every module of the block

package rgbhsv_pkg;

	localparam int CHAN_BITS = 8;
	localparam int FRAC_BITS = 16;
	// divisor is at most six times the largest channel
	localparam int DIV_BITS  = CHAN_BITS + 3;
	// two front stages plus one stage per quotient bit
	localparam int LATENCY   = FRAC_BITS + 2;

	typedef logic [CHAN_BITS-1:0] chan_t;
	typedef logic [FRAC_BITS-1:0] frac_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// one restoring divider in flight: partial remainder, dividend bits still
	// to shift in, quotient so far and the divisor
	typedef struct packed {
		logic [DIV_BITS-1:0] rem;
		frac_t               low;
		frac_t               quo;
		logic [DIV_BITS-1:0] dvsr;
	} div_lane_t;

	typedef struct packed {
		logic      grey;
		chan_t     bright;
		div_lane_t sat;
		div_lane_t hue;
	} div_beat_t;

	// one quotient bit; remainder stays below the divisor
	function automatic div_lane_t div_iter(div_lane_t l);
		logic [DIV_BITS:0] trial;
		logic [DIV_BITS:0] diff;
		div_lane_t         r;
		r     = l;
		trial = {l.rem, l.low[FRAC_BITS-1]};
		diff  = trial - {1'b0, l.dvsr};
		r.low = {l.low[FRAC_BITS-2:0], 1'b0};
		if (trial >= {1'b0, l.dvsr}) begin
			r.rem = diff[DIV_BITS-1:0];
			r.quo = {l.quo[FRAC_BITS-2:0], 1'b1};
		end else begin
			r.rem = trial[DIV_BITS-1:0];
			r.quo = {l.quo[FRAC_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/rgb_to_hsv_converter.sv @@
`timescale 1ns / 1ps
// rgb to hsv converter top level: front stages and the divider pipeline
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div_step
//
// usage
//   input channel : in_valid / in_ready with red, green, blue (8 bit each)
//   output channel: out_valid / out_ready with hue, saturation (16 bit each)
//                   and brightness (8 bit)
//   one pixel in, one result out, in order
// stages: two front stages (max/min, then delta and dividends) and sixteen
//   divider stages that each make one quotient bit of both divisions
// throughput: one pixel per cycle while the receiver keeps out_ready high
// stall: the whole pipeline holds when a result is shown and not taken;
//   in_ready drops with it, so nothing is lost or repeated; bubbles inside
//   the pipeline hold their place while the output waits
// reset: arst_n clears all valid bits; the pipeline comes up empty and
//   ready at once
// grey pixels (all channels equal) give zero hue and zero saturation

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  chan_t red,
	input  chan_t green,
	input  chan_t blue,
	output logic  out_valid,
	input  logic  out_ready,
	output frac_t hue,
	output frac_t saturation,
	output chan_t brightness
);

	logic      en;
	logic      stage_valid [0:FRAC_BITS];
	div_beat_t stage_beat  [0:FRAC_BITS];

	// advance unless a finished result is waiting
	assign en       = !stage_valid[FRAC_BITS] || out_ready;
	assign in_ready = en;

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (stage_valid[0]),
		.out_beat  (stage_beat[0])
	);

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
		rgbhsv_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stage_valid[i]),
			.in_beat   (stage_beat[i]),
			.out_valid (stage_valid[i+1]),
			.out_beat  (stage_beat[i+1])
		);
	end

	assign out_valid  = stage_valid[FRAC_BITS];
	// divisor is zero for grey pixels, so the quotients are masked
	assign hue        = stage_beat[FRAC_BITS].grey ? '0 : stage_beat[FRAC_BITS].hue.quo;
	assign saturation = stage_beat[FRAC_BITS].grey ? '0 : stage_beat[FRAC_BITS].sat.quo;
	assign brightness = stage_beat[FRAC_BITS].bright;

endmodule

@@ rtl/rgbhsv_front.sv @@
`timescale 1ns / 1ps
// front stages: max/min and sector pick, then delta and the two dividends
// depends on rgbhsv_pkg

module rgbhsv_front import rgbhsv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  chan_t     red,
	input  chan_t     green,
	input  chan_t     blue,
	output logic      out_valid,
	output div_beat_t out_beat
);

	chan_t                  hi_c, lo_c;
	sector_t                sector_c;
	logic signed [CHAN_BITS:0] diff_c;

	logic                   valid_s1;
	chan_t                  hi_s1, lo_s1;
	sector_t                sector_s1;
	logic signed [CHAN_BITS:0] diff_s1;

	chan_t                           delta_c;
	logic [CHAN_BITS+FRAC_BITS-1:0]  sat_num_c;
	logic [DIV_BITS-1:0]             offset_c, six_c;
	logic signed [DIV_BITS:0]        num_c, num_wrap_c;
	div_beat_t                       beat_c;

	logic                            valid_s2;
	div_beat_t                       beat_s2;

	always_comb begin
		hi_c = red;
		lo_c = red;
		if (green > hi_c) hi_c = green;
		if (blue > hi_c)  hi_c = blue;
		if (green < lo_c) lo_c = green;
		if (blue < lo_c)  lo_c = blue;
		// red wins ties, then green
		if (red >= hi_c) begin
			sector_c = SEC_RED;
			diff_c   = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= hi_c) begin
			sector_c = SEC_GREEN;
			diff_c   = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sector_c = SEC_BLUE;
			diff_c   = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1     <= hi_c;
			lo_s1     <= lo_c;
			sector_s1 <= sector_c;
			diff_s1   <= diff_c;
			beat_s2   <= beat_c;
		end
	end

	always_comb begin
		delta_c   = hi_s1 - lo_s1;
		// delta * (2^F - 1) as a shift and subtract
		sat_num_c = {delta_c, {FRAC_BITS{1'b0}}}
			- {{FRAC_BITS{1'b0}}, delta_c};
		six_c     = {1'b0, delta_c, 2'b00} + {2'b00, delta_c, 1'b0};
		unique case (sector_s1)
			SEC_RED:   offset_c = '0;
			SEC_GREEN: offset_c = {2'b00, delta_c, 1'b0};
			SEC_BLUE:  offset_c = {1'b0, delta_c, 2'b00};
			default:   offset_c = '0;
		endcase
		num_c = $signed({1'b0, offset_c}) + {{3{diff_s1[CHAN_BITS]}}, diff_s1};
		// negative hue wraps by one turn
		if (num_c < 0)
			num_wrap_c = num_c + $signed({1'b0, six_c});
		else
			num_wrap_c = num_c;

		beat_c.grey     = (delta_c == '0);
		beat_c.bright   = hi_s1;
		beat_c.sat.rem  = DIV_BITS'(sat_num_c[CHAN_BITS+FRAC_BITS-1:FRAC_BITS]);
		beat_c.sat.low  = sat_num_c[FRAC_BITS-1:0];
		beat_c.sat.quo  = '0;
		beat_c.sat.dvsr = DIV_BITS'(hi_s1);
		beat_c.hue.rem  = num_wrap_c[DIV_BITS-1:0];
		beat_c.hue.low  = '0;
		beat_c.hue.quo  = '0;
		beat_c.hue.dvsr = six_c;
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

@@ rtl/rgbhsv_div_step.sv @@
`timescale 1ns / 1ps
// one registered divider stage: a quotient bit for saturation and for hue
// depends on rgbhsv_pkg

module rgbhsv_div_step import rgbhsv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  div_beat_t in_beat,
	output logic      out_valid,
	output div_beat_t out_beat
);

	logic      valid_q;
	div_beat_t beat_q;
	div_beat_t beat_c;

	always_comb begin
		beat_c     = in_beat;
		beat_c.sat = div_iter(in_beat.sat);
		beat_c.hue = div_iter(in_beat.hue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= beat_c;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

endmodule

@@ rtl/rgbhsv_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the rgb to hsv converter, bound to the top level
// depends on rgbhsv_pkg and rgb_to_hsv_converter

module rgbhsv_checker import rgbhsv_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input chan_t red,
	input chan_t green,
	input chan_t blue,
	input logic  out_valid,
	input logic  out_ready,
	input frac_t hue,
	input frac_t saturation,
	input chan_t brightness
);

	// an offered input beat holds still until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid
			&& $stable(red) && $stable(green) && $stable(blue))
		else $error("input beat changed while stalled");

	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable(hue) && $stable(saturation) && $stable(brightness))
		else $error("result beat changed while stalled");

	// the input side only stalls behind an untaken result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output stall");

	// a black pixel is grey
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with hue or saturation");

	// any colour gives nonzero saturation, so zero saturation means grey
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == '0 |-> hue == '0)
		else $error("hue set on a grey pixel");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_chk (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for rgb_to_hsv_converter: directed and random pixels with stalls
// depends on rgbhsv_pkg and the converter rtl; a scoreboard class predicts each result

module tb_top import rgbhsv_pkg::*; ();

	localparam int HOLD_CYCLES = 200;
	localparam int BURST_ITEMS = 60;

	typedef struct packed {
		frac_t hue;
		frac_t sat;
		chan_t bright;
	} hsv_t;

	class hsv_scoreboard;
		hsv_t pending_hsv[$];
		int   errors;

		function new();
			errors = 0;
		endfunction

		static function hsv_t predict_hsv(chan_t r, chan_t g, chan_t b);
			int      hi;
			int      lo;
			int      delta;
			int      dif;
			int      offs;
			int      num;
			sector_t sec;
			hsv_t    res;
			hi = r;
			lo = r;
			if (g > hi) hi = g;
			if (b > hi) hi = b;
			if (g < lo) lo = g;
			if (b < lo) lo = b;
			delta = hi - lo;
			res.hue = '0;
			res.sat = '0;
			res.bright = chan_t'(hi);
			if (delta != 0) begin
				res.sat = frac_t'((delta * ((1 << FRAC_BITS) - 1)) / hi);
				// ties go to red first, then green
				if (int'(r) == hi) begin
					sec = SEC_RED;
					dif = int'(g) - int'(b);
				end else if (int'(g) == hi) begin
					sec = SEC_GREEN;
					dif = int'(b) - int'(r);
				end else begin
					sec = SEC_BLUE;
					dif = int'(r) - int'(g);
				end
				case (sec)
					SEC_RED:   offs = 0;
					SEC_GREEN: offs = 2;
					default:   offs = 4;
				endcase
				num = offs * delta + dif;
				// negative hue wraps by one full turn
				if (num < 0) num += 6 * delta;
				res.hue = frac_t'((longint'(num) << FRAC_BITS) / longint'(6 * delta));
			end
			return res;
		endfunction

		function void note_pixel(chan_t r, chan_t g, chan_t b);
			pending_hsv.push_back(predict_hsv(r, g, b));
		endfunction

		function int outstanding();
			return pending_hsv.size();
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 100)
				$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_result(frac_t h, frac_t s, chan_t v);
			hsv_t want;
			if (pending_hsv.size() == 0) begin
				report_mismatch($sformatf("unexpected result hue %0d sat %0d bright %0d",
					h, s, v));
			end else begin
				want = pending_hsv.pop_front();
				if (h !== want.hue || s !== want.sat || v !== want.bright)
					report_mismatch($sformatf(
						"hue %0d/%0d sat %0d/%0d bright %0d/%0d (got/want)",
						h, want.hue, s, want.sat, v, want.bright));
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  out_valid;
	logic  out_ready;
	frac_t hue;
	frac_t saturation;
	chan_t brightness;

	bit no_idle;
	bit hold_req;

	hsv_scoreboard sb;

	rgb_to_hsv_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(chan_t r, chan_t g, chan_t b);
		int gap;
		in_valid = 1'b1;
		red = r;
		green = g;
		blue = b;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(r, g, b);
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// random pixel, weighted towards greys, ties and small deltas
	task automatic send_random_pixel();
		int    p;
		chan_t base;
		chan_t r;
		chan_t g;
		chan_t b;
		p = $urandom_range(0, 99);
		r = chan_t'($urandom);
		g = chan_t'($urandom);
		b = chan_t'($urandom);
		if (p >= 60 && p < 70) begin
			g = r;
			b = r;
		end else if (p >= 70 && p < 85) begin
			case ($urandom_range(0, 2))
				0:       g = r;
				1:       b = g;
				default: b = r;
			endcase
		end else if (p >= 85) begin
			base = chan_t'($urandom_range(0, 250));
			r = base + chan_t'($urandom_range(0, 5));
			g = base + chan_t'($urandom_range(0, 5));
			b = base + chan_t'($urandom_range(0, 5));
		end
		send_pixel(r, g, b);
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(hue, saturation, brightness);
	end

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		int left;
		left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready = 1'b1;
				left = 0;
			end else if (no_idle) begin
				out_ready = 1'b1;
			end else if (left > 0) begin
				left--;
			end else if (out_ready) begin
				out_ready = 1'b0;
				left = pick_gap();
			end else begin
				out_ready = 1'b1;
				left = $urandom_range(0, 15);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		sb = new();
		no_idle = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// greys, primaries, ties and the wrap of a negative hue
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd1, 8'd255);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd2, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);

		repeat (200) send_random_pixel();

		// sender pauses until the pipeline has drained
		in_valid = 1'b0;
		wait_drained();
		@(negedge clk);

		// receiver holds off while the sender keeps offering beats
		no_idle = 1'b1;
		hold_req = 1'b1;
		repeat (BURST_ITEMS) send_random_pixel();

		// stretch with no idling on either side
		repeat (100) send_random_pixel();
		no_idle = 1'b0;

		repeat (170) send_random_pixel();

		in_valid = 1'b0;
		wait_drained();
		repeat (LATENCY + 20) @(negedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
